[rtl/core/tgpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task graph dispatcher package
// Shared widths, status codes, operation codes and cell interface types.
// ----------------------------------------------------------------------------
package tgpd_pkg;

  localparam int unsigned NumTasks = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned CntW     = 7;
  localparam logic [CntW-1:0] CntMax = 7'd127;
  localparam int unsigned SegLen   = 8;
  localparam int unsigned NumSeg   = (NumTasks + SegLen - 1) / SegLen;
  localparam int unsigned WalkW    = $clog2(NumSeg + 1);

  typedef enum logic [1:0] {
    OP_ADD_NODE = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_REQUEST  = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_BUILT  = 2'd0,
    OUT_CUT    = 2'd1,
    OUT_CLEAN  = 2'd2,
    OUT_FAILED = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_PENDING = 3'd1,
    ST_READY   = 3'd2,
    ST_RUNNING = 3'd3,
    ST_BUILT   = 3'd4,
    ST_CUT     = 3'd5,
    ST_CLEAN   = 3'd6,
    ST_FAILED  = 3'd7
  } status_e;

  // Command broadcast to every cell for one cycle.
  typedef struct packed {
    logic             add_node;
    logic             add_edge;
    logic             promote;
    logic             grant;
    logic             finish;
    logic             unblock;
    logic             fail_mark;
    logic [IdxW-1:0]  node;
    logic [IdxW-1:0]  other;
    logic [PrioW-1:0] prio;
    logic             other_final;
    status_e          new_status;
    logic [NumTasks-1:0] fail_set;
  } cell_cmd_t;

  // Candidate travelling along the chain during the selection pass.
  typedef struct packed {
    logic             found;
    logic [IdxW-1:0]  idx;
    logic [PrioW-1:0] prio;
  } cand_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v < CntMax) ? v + 1'b1 : CntMax;
  endfunction

endpackage

[rtl/core/task_graph_priority_dispatcher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task graph priority dispatcher
// Channel   Direction  Signals
// request   in         start, busy, operation_i, node_index_i, other_index_i,
//                      priority_req_i, outcome_i
// result    out        result_valid_o, granted_o ... bad_report_o
// Add node and add edge go from the apply state straight to the result state.
// A dispatch request promotes pending tasks with no unmet count, then walks the
// candidate through the 64 cells in eight registered segments. A completion goes
// to the result, or, when it fails, through the cascade state, which marks one
// failed level downstream at a time. Busy falls in the cycle after the result.
// Reset clears task status, unmet counts and successor rows at once, not priorities.
// The result is shown for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module task_graph_priority_dispatcher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation_i,
  input  logic [tgpd_pkg::IdxW-1:0]      node_index_i,
  input  logic [tgpd_pkg::IdxW-1:0]      other_index_i,
  input  logic [tgpd_pkg::PrioW-1:0]     priority_req_i,
  input  logic [1:0]                     outcome_i,
  output logic                           result_valid_o,
  output logic                           granted_o,
  output logic [tgpd_pkg::IdxW-1:0]      grant_index_o,
  output logic                           all_done_o,
  output logic [tgpd_pkg::CntW-1:0]      running_now_o,
  output logic [tgpd_pkg::CntW-1:0]      built_total_o,
  output logic [tgpd_pkg::CntW-1:0]      cut_total_o,
  output logic [tgpd_pkg::CntW-1:0]      clean_total_o,
  output logic [tgpd_pkg::CntW-1:0]      failed_total_o,
  output logic                           bad_report_o
);

  localparam int unsigned N = tgpd_pkg::NumTasks;
  localparam logic [tgpd_pkg::WalkW-1:0] WalkLen = tgpd_pkg::WalkW'(tgpd_pkg::NumSeg);

  typedef enum logic [2:0] {
    S_IDLE, S_APPLY, S_WALK, S_CASCADE, S_RESULT
  } state_e;

  state_e state_q;
  logic [tgpd_pkg::WalkW-1:0] walk_q;
  tgpd_pkg::op_e op_q;
  logic [tgpd_pkg::IdxW-1:0] node_q, other_q;
  logic [tgpd_pkg::PrioW-1:0] prio_q;
  logic [1:0] outc_q;
  logic [N-1:0] front_q;
  logic [tgpd_pkg::CntW-1:0] run_q, built_q, cut_q, clean_q, fail_q;
  logic granted_q, done_q, bad_q;
  logic [tgpd_pkg::IdxW-1:0] gidx_q;

  tgpd_pkg::cell_cmd_t cmd;
  tgpd_pkg::cand_t cand;
  tgpd_pkg::status_e status [N];
  logic [N-1:0] succ [N];
  logic [N-1:0] dec, reach, newfail;
  logic node_running;
  tgpd_pkg::status_e fin_status;
  logic [tgpd_pkg::CntW:0] fail_sum;

  assign node_running = (status[node_q] == tgpd_pkg::ST_RUNNING);
  assign dec = succ[node_q];
  assign fail_sum = {1'b0, fail_q} + (tgpd_pkg::CntW + 1)'($countones(newfail));

  always_comb begin
    case (outc_q)
      tgpd_pkg::OUT_BUILT: fin_status = tgpd_pkg::ST_BUILT;
      tgpd_pkg::OUT_CUT:   fin_status = tgpd_pkg::ST_CUT;
      tgpd_pkg::OUT_CLEAN: fin_status = tgpd_pkg::ST_CLEAN;
      default:             fin_status = tgpd_pkg::ST_FAILED;
    endcase
  end

  always_comb begin
    reach = '0;
    for (int u = 0; u < N; u++) begin
      if (front_q[u]) reach = reach | succ[u];
    end
    for (int t = 0; t < N; t++) begin
      newfail[t] = reach[t] && (status[t] == tgpd_pkg::ST_PENDING ||
                                status[t] == tgpd_pkg::ST_READY);
    end
  end

  always_comb begin
    cmd = '0;
    cmd.node = node_q;
    cmd.other = other_q;
    cmd.prio = prio_q;
    cmd.other_final = status[other_q] inside {tgpd_pkg::ST_BUILT, tgpd_pkg::ST_CUT,
                                              tgpd_pkg::ST_CLEAN, tgpd_pkg::ST_FAILED};
    cmd.new_status = fin_status;
    cmd.fail_set = newfail;
    if (state_q == S_APPLY) begin
      case (op_q)
        tgpd_pkg::OP_ADD_NODE: cmd.add_node = 1'b1;
        tgpd_pkg::OP_ADD_EDGE: cmd.add_edge = !succ[other_q][node_q];
        tgpd_pkg::OP_REQUEST:  cmd.promote = 1'b1;
        default: begin
          cmd.finish  = node_running;
          cmd.unblock = node_running;
        end
      endcase
    end
    if (state_q == S_WALK && walk_q == WalkLen && cand.found) begin
      cmd.grant = 1'b1;
      cmd.node = cand.idx;
    end
    if (state_q == S_CASCADE) cmd.fail_mark = 1'b1;
  end

  tgpd_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .dec_i    (dec),
    .cand_o   (cand),
    .status_o (status),
    .succ_o   (succ)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q <= '0;
      op_q <= tgpd_pkg::OP_ADD_NODE;
      node_q <= '0;
      other_q <= '0;
      prio_q <= '0;
      outc_q <= '0;
      front_q <= '0;
      run_q <= '0;
      built_q <= '0;
      cut_q <= '0;
      clean_q <= '0;
      fail_q <= '0;
      granted_q <= 1'b0;
      done_q <= 1'b0;
      bad_q <= 1'b0;
      gidx_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q <= tgpd_pkg::op_e'(operation_i);
            node_q <= node_index_i;
            other_q <= other_index_i;
            prio_q <= priority_req_i;
            outc_q <= outcome_i;
            granted_q <= 1'b0;
            done_q <= 1'b0;
            bad_q <= 1'b0;
            gidx_q <= '0;
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (op_q == tgpd_pkg::OP_REQUEST) begin
            walk_q <= '0;
            state_q <= S_WALK;
          end else if (op_q == tgpd_pkg::OP_COMPLETE) begin
            if (!node_running) begin
              bad_q <= 1'b1;
              state_q <= S_RESULT;
            end else begin
              run_q <= (run_q != '0) ? run_q - 1'b1 : '0;
              case (outc_q)
                tgpd_pkg::OUT_BUILT: begin
                  built_q <= tgpd_pkg::sat_inc(built_q);
                  state_q <= S_RESULT;
                end
                tgpd_pkg::OUT_CUT: begin
                  cut_q <= tgpd_pkg::sat_inc(cut_q);
                  state_q <= S_RESULT;
                end
                tgpd_pkg::OUT_CLEAN: begin
                  clean_q <= tgpd_pkg::sat_inc(clean_q);
                  state_q <= S_RESULT;
                end
                default: begin
                  fail_q <= tgpd_pkg::sat_inc(fail_q);
                  front_q <= N'(1) << node_q;
                  state_q <= S_CASCADE;
                end
              endcase
            end
          end else begin
            state_q <= S_RESULT;
          end
        end
        S_WALK: begin
          walk_q <= walk_q + 1'b1;
          if (walk_q == WalkLen) begin
            if (cand.found) begin
              granted_q <= 1'b1;
              gidx_q <= cand.idx;
              run_q <= tgpd_pkg::sat_inc(run_q);
            end else begin
              done_q <= (run_q == '0);
            end
            state_q <= S_RESULT;
          end
        end
        S_CASCADE: begin
          front_q <= newfail;
          if (fail_sum >= {1'b0, tgpd_pkg::CntMax}) begin
            fail_q <= tgpd_pkg::CntMax;
          end else begin
            fail_q <= fail_sum[tgpd_pkg::CntW-1:0];
          end
          if (newfail == '0) state_q <= S_RESULT;
        end
        S_RESULT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESULT);
  assign granted_o = granted_q;
  assign grant_index_o = gidx_q;
  assign all_done_o = done_q;
  assign running_now_o = run_q;
  assign built_total_o = built_q;
  assign cut_total_o = cut_q;
  assign clean_total_o = clean_q;
  assign failed_total_o = fail_q;
  assign bad_report_o = bad_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Result shown for more than one cycle.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(granted_q && done_q))
    else $error("Grant and done reported together.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start) |=> busy)
    else $error("Accepted request did not raise busy.");

endmodule

[rtl/core/tgpd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task cell
// Holds one task's status, priority, unmet count and successor row, and
// passes the best ready candidate on to its neighbour.
// ----------------------------------------------------------------------------
module tgpd_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [tgpd_pkg::IdxW-1:0]         idx_i,
  input  tgpd_pkg::cell_cmd_t               cmd_i,
  input  logic                              dec_i,
  input  tgpd_pkg::cand_t                   cand_i,
  output tgpd_pkg::cand_t                   cand_o,
  output tgpd_pkg::status_e                 status_o,
  output logic [tgpd_pkg::NumTasks-1:0]     succ_o
);

  tgpd_pkg::status_e                status_q, status_d;
  logic [tgpd_pkg::PrioW-1:0]       prio_q, prio_d;
  logic [tgpd_pkg::CntW-1:0]        unmet_q, unmet_d;
  logic [tgpd_pkg::NumTasks-1:0]    succ_q, succ_d;
  logic                             self_node, self_other;

  assign self_node  = (cmd_i.node == idx_i);
  assign self_other = (cmd_i.other == idx_i);

  always_comb begin
    status_d = status_q;
    prio_d   = prio_q;
    unmet_d  = unmet_q;
    succ_d   = succ_q;
    if (cmd_i.add_node && self_node && status_q == tgpd_pkg::ST_UNUSED) begin
      status_d = tgpd_pkg::ST_PENDING;
      prio_d   = cmd_i.prio;
    end
    if (cmd_i.add_edge) begin
      if (self_other) begin
        succ_d[cmd_i.node] = 1'b1;
      end
      if (self_node && !cmd_i.other_final) begin
        unmet_d = tgpd_pkg::sat_inc(unmet_q);
      end
    end
    if (cmd_i.promote && status_q == tgpd_pkg::ST_PENDING && unmet_q == '0) begin
      status_d = tgpd_pkg::ST_READY;
    end
    if (cmd_i.grant && self_node) begin
      status_d = tgpd_pkg::ST_RUNNING;
    end
    if (cmd_i.finish && self_node) begin
      status_d = cmd_i.new_status;
    end
    if (cmd_i.unblock && dec_i && unmet_q != '0) begin
      unmet_d = unmet_q - 1'b1;
    end
    if (cmd_i.fail_mark && cmd_i.fail_set[idx_i]) begin
      status_d = tgpd_pkg::ST_FAILED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= tgpd_pkg::ST_UNUSED;
      unmet_q  <= '0;
      succ_q   <= '0;
    end else begin
      status_q <= status_d;
      unmet_q  <= unmet_d;
      succ_q   <= succ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
  end

  always_comb begin
    cand_o = cand_i;
    if (status_q == tgpd_pkg::ST_READY && (!cand_i.found || prio_q > cand_i.prio)) begin
      cand_o.found = 1'b1;
      cand_o.idx   = idx_i;
      cand_o.prio  = prio_q;
    end
  end

  assign status_o = status_q;
  assign succ_o   = succ_q;

endmodule

[rtl/core/tgpd_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell chain
// A row of task cells with the selection candidate handed along, registered
// every eight cells.
// ----------------------------------------------------------------------------
module tgpd_chain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tgpd_pkg::cell_cmd_t               cmd_i,
  input  logic [tgpd_pkg::NumTasks-1:0]     dec_i,
  output tgpd_pkg::cand_t                   cand_o,
  output tgpd_pkg::status_e                 status_o [tgpd_pkg::NumTasks],
  output logic [tgpd_pkg::NumTasks-1:0]     succ_o   [tgpd_pkg::NumTasks]
);

  tgpd_pkg::cand_t link [tgpd_pkg::NumTasks+1];
  tgpd_pkg::cand_t seg_q [tgpd_pkg::NumSeg];

  assign link[0] = '0;

  for (genvar g = 0; g < tgpd_pkg::NumTasks; g++) begin : g_cell
    tgpd_pkg::cand_t cin;
    if (g % tgpd_pkg::SegLen == 0 && g != 0) begin : g_reg
      assign cin = seg_q[g / tgpd_pkg::SegLen - 1];
    end else begin : g_comb
      assign cin = link[g];
    end
    tgpd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (tgpd_pkg::IdxW'(g)),
      .cmd_i    (cmd_i),
      .dec_i    (dec_i[g]),
      .cand_i   (cin),
      .cand_o   (link[g+1]),
      .status_o (status_o[g]),
      .succ_o   (succ_o[g])
    );
  end

  for (genvar s = 0; s < tgpd_pkg::NumSeg; s++) begin : g_seg
    always_ff @(posedge clk_i) begin
      seg_q[s] <= link[((s + 1) * tgpd_pkg::SegLen > tgpd_pkg::NumTasks) ?
                       tgpd_pkg::NumTasks : (s + 1) * tgpd_pkg::SegLen];
    end
  end

  assign cand_o = seg_q[tgpd_pkg::NumSeg-1];

endmodule

[test/tgpd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task graph dispatcher checker
// Watches the request and result channels of the dispatcher, keeps its own
// model of the task graph, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module tgpd_checker
  import tgpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       operation_i,
  input  logic [IdxW-1:0]  node_index_i,
  input  logic [IdxW-1:0]  other_index_i,
  input  logic [PrioW-1:0] priority_req_i,
  input  logic [1:0]       outcome_i,
  input  logic             result_valid_i,
  input  logic             granted_i,
  input  logic [IdxW-1:0]  grant_index_i,
  input  logic             all_done_i,
  input  logic [CntW-1:0]  running_now_i,
  input  logic [CntW-1:0]  built_total_i,
  input  logic [CntW-1:0]  cut_total_i,
  input  logic [CntW-1:0]  clean_total_i,
  input  logic [CntW-1:0]  failed_total_i,
  input  logic             bad_report_i,
  output int               fail_count_o,
  output int               pending_count_o,
  output int               grant_count_o
);

  typedef struct packed {
    logic            granted;
    logic [IdxW-1:0] grant_index;
    logic            all_done;
    logic [CntW-1:0] running_now;
    logic [CntW-1:0] built_total;
    logic [CntW-1:0] cut_total;
    logic [CntW-1:0] clean_total;
    logic [CntW-1:0] failed_total;
    logic            bad_report;
  } outcome_t;

  status_e              status_q [NumTasks];
  logic [PrioW-1:0]     prio_q [NumTasks];
  logic [CntW-1:0]      unmet_q [NumTasks];
  logic [NumTasks-1:0]  succ_q [NumTasks];
  logic [CntW-1:0]      running_q, built_q, cut_q, clean_q, failed_q;
  outcome_t             expected_q [$];

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v < CntMax) ? v + 1'b1 : CntMax;
  endfunction

  function automatic logic [CntW-1:0] drop(input logic [CntW-1:0] v);
    return (v > 0) ? v - 1'b1 : '0;
  endfunction

  task automatic fail_downstream(input int origin);
    int stack [$];
    int u;
    stack.push_back(origin);
    while (stack.size() > 0) begin
      u = stack.pop_back();
      for (int t = 0; t < NumTasks; t++) begin
        if (succ_q[u][t] && (status_q[t] == ST_PENDING || status_q[t] == ST_READY)) begin
          status_q[t] = ST_FAILED;
          failed_q = bump(failed_q);
          stack.push_back(t);
        end
      end
    end
  endtask

  task automatic predict_request(input logic [1:0] op, input int node, input int oth,
                                 input logic [PrioW-1:0] prio, input logic [1:0] outc);
    outcome_t r;
    logic found;
    int best;
    r = '0;
    found = 1'b0;
    best = 0;
    case (op)
      OP_ADD_NODE: begin
        if (status_q[node] == ST_UNUSED) begin
          status_q[node] = ST_PENDING;
          prio_q[node] = prio;
        end
      end
      OP_ADD_EDGE: begin
        if (!succ_q[oth][node]) begin
          succ_q[oth][node] = 1'b1;
          if (status_q[oth] < ST_BUILT) unmet_q[node] = bump(unmet_q[node]);
        end
      end
      OP_REQUEST: begin
        for (int i = 0; i < NumTasks; i++) begin
          if (status_q[i] == ST_PENDING && unmet_q[i] == 0) status_q[i] = ST_READY;
          if (status_q[i] == ST_READY && (!found || prio_q[i] > prio_q[best])) begin
            found = 1'b1;
            best = i;
          end
        end
        if (found) begin
          status_q[best] = ST_RUNNING;
          running_q = bump(running_q);
          r.granted = 1'b1;
          r.grant_index = IdxW'(best);
        end else if (running_q == 0) begin
          r.all_done = 1'b1;
        end
      end
      default: begin
        if (status_q[node] != ST_RUNNING) begin
          r.bad_report = 1'b1;
        end else begin
          running_q = drop(running_q);
          case (outc)
            OUT_BUILT: begin status_q[node] = ST_BUILT; built_q = bump(built_q); end
            OUT_CUT:   begin status_q[node] = ST_CUT;   cut_q = bump(cut_q); end
            OUT_CLEAN: begin status_q[node] = ST_CLEAN; clean_q = bump(clean_q); end
            default: begin
              status_q[node] = ST_FAILED;
              failed_q = bump(failed_q);
              fail_downstream(node);
            end
          endcase
          for (int t = 0; t < NumTasks; t++)
            if (succ_q[node][t]) unmet_q[t] = drop(unmet_q[t]);
        end
      end
    endcase
    r.running_now = running_q;
    r.built_total = built_q;
    r.cut_total = cut_q;
    r.clean_total = clean_q;
    r.failed_total = failed_q;
    expected_q.push_back(r);
  endtask

  assign pending_count_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NumTasks; i++) begin
        status_q[i] = ST_UNUSED;
        prio_q[i] = '0;
        unmet_q[i] = '0;
        succ_q[i] = '0;
      end
      running_q = '0; built_q = '0; cut_q = '0; clean_q = '0; failed_q = '0;
      expected_q.delete();
      fail_count_o = 0;
      grant_count_o = 0;
    end else begin
      if (result_valid_i) begin
        got = '{granted_i, grant_index_i, all_done_i, running_now_i, built_total_i,
                cut_total_i, clean_total_i, failed_total_i, bad_report_i};
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("Unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("Mismatch: expected %p, actual %p", want, got);
          end
          if (got.granted) grant_count_o++;
        end
      end
      if (start_i && !busy_i)
        predict_request(operation_i, node_index_i, other_index_i, priority_req_i, outcome_i);
    end
  end

endmodule

[test/tb_task_graph_priority_dispatcher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task graph priority dispatcher testbench
// Builds random task graphs, dispatches and completes their tasks with random
// outcomes, mixes in malformed requests, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb_task_graph_priority_dispatcher_core;
  import tgpd_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       operation_i = '0;
  logic [IdxW-1:0]  node_index_i = '0;
  logic [IdxW-1:0]  other_index_i = '0;
  logic [PrioW-1:0] priority_req_i = '0;
  logic [1:0]       outcome_i = '0;
  logic             result_valid_o, granted_o, all_done_o, bad_report_o;
  logic [IdxW-1:0]  grant_index_o;
  logic [CntW-1:0]  running_now_o, built_total_o, cut_total_o, clean_total_o;
  logic [CntW-1:0]  failed_total_o;
  int               fail_count, pending_count, grant_count, sent;
  int               running_list [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task_graph_priority_dispatcher_core i_dut (.*);

  tgpd_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .operation_i, .node_index_i,
    .other_index_i, .priority_req_i, .outcome_i, .result_valid_i(result_valid_o),
    .granted_i(granted_o), .grant_index_i(grant_index_o), .all_done_i(all_done_o),
    .running_now_i(running_now_o), .built_total_i(built_total_o),
    .cut_total_i(cut_total_o), .clean_total_i(clean_total_o),
    .failed_total_i(failed_total_o), .bad_report_i(bad_report_o),
    .fail_count_o(fail_count), .pending_count_o(pending_count),
    .grant_count_o(grant_count)
  );

  task automatic send_request(input op_e op, input int node, input int oth,
                              input int prio, input int outc);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    node_index_i <= IdxW'(node);
    other_index_i <= IdxW'(oth);
    priority_req_i <= PrioW'(prio);
    outcome_i <= 2'(outc);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    sent++;
    if (op == OP_REQUEST) begin
      while (!result_valid_o) @(posedge clk_i);
      if (granted_o) running_list.push_back(int'(grant_index_o));
    end
  endtask

  task automatic complete_one(input int outc);
    int k;
    k = $urandom_range(0, running_list.size() - 1);
    send_request(OP_COMPLETE, running_list[k], $urandom, $urandom, outc);
    running_list.delete(k);
  endtask

  initial begin
    #20000000;
    $display("tb_task_graph_priority_dispatcher_core failed");
    $finish;
  end

  initial begin
    int n, base, a;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extremes, ties, duplicates, self edge, cycle, bad completions.
    send_request(OP_REQUEST, 0, 0, 0, OUT_BUILT);
    send_request(OP_COMPLETE, 63, 0, 0, OUT_BUILT);
    send_request(OP_ADD_NODE, 0, 0, 16'hffff, 0);
    send_request(OP_ADD_NODE, 63, 63, 16'hffff, 3);
    send_request(OP_ADD_NODE, 0, 0, 16'h0000, 0);
    send_request(OP_ADD_NODE, 5, 0, 16'h0000, 0);
    send_request(OP_ADD_EDGE, 5, 0, 0, 0);
    send_request(OP_ADD_EDGE, 5, 0, 0, 0);
    send_request(OP_ADD_EDGE, 10, 10, 0, 0);
    send_request(OP_ADD_NODE, 10, 0, 16'h1234, 0);
    send_request(OP_ADD_EDGE, 20, 21, 0, 0);
    send_request(OP_ADD_EDGE, 21, 20, 0, 0);
    send_request(OP_ADD_NODE, 20, 0, 1, 0);
    send_request(OP_ADD_NODE, 21, 0, 2, 0);
    send_request(OP_REQUEST, 0, 0, 0, 0);
    send_request(OP_REQUEST, 0, 0, 0, 0);
    send_request(OP_COMPLETE, 5, 0, 0, OUT_BUILT);
    send_request(OP_ADD_EDGE, 30, 0, 0, 0);
    while (running_list.size() > 0) complete_one(running_list[0] == 0 ? OUT_FAILED : OUT_CLEAN);
    send_request(OP_ADD_EDGE, 33, 63, 0, 0);
    send_request(OP_REQUEST, 0, 0, 0, 0);
    while (running_list.size() > 0) complete_one(OUT_CUT);
    send_request(OP_REQUEST, 0, 0, 0, 0);
    // Random: graph rounds in a sliding window of slots, with noise.
    while (sent < 1300) begin
      n = $urandom_range(3, 12);
      base = $urandom_range(0, 63);
      for (int i = 0; i < n; i++)
        send_request(OP_ADD_NODE, (base + i) % 64, $urandom,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom, $urandom);
      repeat ($urandom_range(0, n)) begin
        a = $urandom_range(1, n - 1);
        send_request(OP_ADD_EDGE, (base + a) % 64, (base + $urandom_range(0, a - 1)) % 64,
                     $urandom, $urandom);
      end
      repeat (n + 4) begin
        case ($urandom_range(0, 9))
          0: send_request(op_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
          1, 2, 3: if (running_list.size() > 0) complete_one($urandom);
                   else send_request(OP_REQUEST, $urandom, $urandom, $urandom, $urandom);
          default: send_request(OP_REQUEST, $urandom, $urandom, $urandom, $urandom);
        endcase
      end
      while (running_list.size() > 0) complete_one($urandom);
    end
    while (pending_count > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests; %0d tasks dispatched and checked.", sent, grant_count);
    if (fail_count == 0) begin
      $display("tb_task_graph_priority_dispatcher_core passed");
    end else begin
      $display("tb_task_graph_priority_dispatcher_core failed");
    end
    $finish;
  end

endmodule
